// ----- hw/rtl/rcbg_pkg.sv -----
// ---------------------------------------------------------------------------
// rcbg_pkg: shared definitions for the RGB contrast, brightness and gain block
// Register indexes, value ranges, pipeline depth and the divide-by-100 helpers
// used by the top level and the per-channel datapath.
// ---------------------------------------------------------------------------
package rcbg_pkg;

    // Number of register stages in the per-channel datapath.
    localparam int NSTG = 9;

    // Fixed-point constants of the adjustment formula.
    localparam int PCT_UNITY  = 100;
    localparam int MID_GREY   = 128;
    localparam int ROUND_HALF = 50;
    localparam int CHAN_MAX   = 255;

    // Reciprocal of 100 scaled by 2^22, rounded down; the quotient it gives
    // is the true quotient or one less, and a single correction step fixes it.
    localparam int RECIP_100   = 41943;
    localparam int RECIP_SHIFT = 22;

    // Register ranges.
    localparam int BRIGHT_MIN = 50;
    localparam int BRIGHT_MAX = 100;
    localparam int PCT_MIN    = 50;
    localparam int PCT_MAX    = 150;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_ENABLE   = 3'd0,
        CFG_BRIGHT   = 3'd1,
        CFG_CONTRAST = 3'd2,
        CFG_RED_GAIN = 3'd3,
        CFG_GRN_GAIN = 3'd4,
        CFG_BLU_GAIN = 3'd5
    } t_cfg_idx;

    // Saturate an 8-bit write value into [lo, hi].
    function automatic logic [7:0] f_sat8(input logic [7:0] v, input logic [7:0] lo,
                                          input logic [7:0] hi);
        logic [7:0] res;
        if (v < lo) begin
            res = lo;
        end else if (v > hi) begin
            res = hi;
        end else begin
            res = v;
        end
        return res;
    endfunction

    // Correct an estimated quotient of x / 100 that may be one too small.
    function automatic logic [8:0] f_div100_fix(input logic [15:0] x,
                                                input logic [8:0] q0);
        logic [16:0] prod;
        logic [16:0] rem;
        logic [8:0]  q;
        prod = 17'(q0) * 17'(PCT_UNITY);
        rem  = {1'b0, x} - prod;
        if (rem >= 17'(PCT_UNITY)) begin
            q = q0 + 9'd1;
        end else begin
            q = q0;
        end
        return q;
    endfunction

endpackage

// ----- hw/rtl/rcbg_chan.sv -----
// ---------------------------------------------------------------------------
// rcbg_chan: one colour channel of the adjustment pipeline
// Contrast about mid-grey, brightness and gain, each a multiply by a percent
// followed by a rounded divide by 100 truncating toward zero, then a clamp.
// Three steps of three stages each: multiply, reciprocal multiply, correct.
// ---------------------------------------------------------------------------
module rcbg_chan (
    input  logic                     i_clk,
    input  logic [rcbg_pkg::NSTG-1:0] i_ld,       // per-stage load enables
    input  logic [7:0]               i_chan,
    input  logic [7:0]               i_contrast,
    input  logic [6:0]               i_bright,
    input  logic [7:0]               i_gain,
    output logic [7:0]               o_val
);

    // Step 1: contrast about mid-grey.
    logic signed [9:0]  w_d;
    logic signed [18:0] w_p1;
    logic               r_neg1_a, r_neg1_b;
    logic [14:0]        r_mag1_a, r_mag1_b;
    logic [30:0]        r_prd1;
    logic [8:0]         w_q1;
    logic signed [9:0]  r_v1;

    // Step 2: brightness.
    logic signed [18:0] w_p2;
    logic               r_neg2_a, r_neg2_b;
    logic [14:0]        r_mag2_a, r_mag2_b;
    logic [30:0]        r_prd2;
    logic [8:0]         w_q2;
    logic signed [9:0]  r_v2;

    // Step 3: channel gain.
    logic signed [18:0] w_p3;
    logic               r_neg3_a, r_neg3_b;
    logic [15:0]        r_mag3_a, r_mag3_b;
    logic [31:0]        r_prd3;
    logic [8:0]         w_q3;
    logic [7:0]         r_out;

    // Signed products plus the rounding half.
    assign w_d  = $signed({2'b00, i_chan}) - 10'sd128;
    assign w_p1 = 19'(w_d) * $signed({11'd0, i_contrast}) + 19'sd50;
    assign w_p2 = 19'(r_v1) * $signed({12'd0, i_bright}) + 19'sd50;
    assign w_p3 = 19'(r_v2) * $signed({11'd0, i_gain}) + 19'sd50;

    // Corrected quotients of the magnitudes.
    assign w_q1 = rcbg_pkg::f_div100_fix(16'(r_mag1_b),
                                         9'(r_prd1 >> rcbg_pkg::RECIP_SHIFT));
    assign w_q2 = rcbg_pkg::f_div100_fix(16'(r_mag2_b),
                                         9'(r_prd2 >> rcbg_pkg::RECIP_SHIFT));
    assign w_q3 = rcbg_pkg::f_div100_fix(r_mag3_b,
                                         9'(r_prd3 >> rcbg_pkg::RECIP_SHIFT));

    // Contrast stages.
    always_ff @(posedge i_clk) begin
        if (i_ld[0]) begin
            r_neg1_a <= w_p1[18];
            r_mag1_a <= w_p1[18] ? 15'(-w_p1) : w_p1[14:0];
        end
        if (i_ld[1]) begin
            r_neg1_b <= r_neg1_a;
            r_mag1_b <= r_mag1_a;
            r_prd1   <= {16'd0, r_mag1_a} * 31'(rcbg_pkg::RECIP_100);
        end
        if (i_ld[2]) begin
            r_v1     <= r_neg1_b ? 10'sd128 - $signed({1'b0, w_q1})
                                 : 10'sd128 + $signed({1'b0, w_q1});
        end
    end

    // Brightness stages.
    always_ff @(posedge i_clk) begin
        if (i_ld[3]) begin
            r_neg2_a <= w_p2[18];
            r_mag2_a <= w_p2[18] ? 15'(-w_p2) : w_p2[14:0];
        end
        if (i_ld[4]) begin
            r_neg2_b <= r_neg2_a;
            r_mag2_b <= r_mag2_a;
            r_prd2   <= {16'd0, r_mag2_a} * 31'(rcbg_pkg::RECIP_100);
        end
        if (i_ld[5]) begin
            r_v2 <= r_neg2_b ? -$signed({1'b0, w_q2}) : $signed({1'b0, w_q2});
        end
    end

    // Gain stages and the final clamp; a negative result clamps to zero.
    always_ff @(posedge i_clk) begin
        if (i_ld[6]) begin
            r_neg3_a <= w_p3[18];
            r_mag3_a <= w_p3[18] ? 16'(-w_p3) : w_p3[15:0];
        end
        if (i_ld[7]) begin
            r_neg3_b <= r_neg3_a;
            r_mag3_b <= r_mag3_a;
            r_prd3   <= {16'd0, r_mag3_a} * 32'(rcbg_pkg::RECIP_100);
        end
        if (i_ld[8]) begin
            if (r_neg3_b) begin
                r_out <= 8'd0;
            end else if (w_q3 > 9'(rcbg_pkg::CHAN_MAX)) begin
                r_out <= 8'(rcbg_pkg::CHAN_MAX);
            end else begin
                r_out <= w_q3[7:0];
            end
        end
    end

    // Clamped channel value from the last stage.
    assign o_val = r_out;

endmodule

// ----- hw/rtl/rgb_contrast_brightness_gain_top.sv -----
// ---------------------------------------------------------------------------
// rgb_contrast_brightness_gain_top: per-pixel colour adjustment
// Applies contrast about mid-grey, brightness and per-channel gain to the
// red, green and blue bytes of a pixel stream; the lowest byte passes through.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Payload (lowest bits first)
//  s_axis    in         top_byte_in, red_in, green_in, blue_in (32 bits)
//  m_axis    out        top_byte_out, red_out, green_out, blue_out (32 bits)
//  cfg       in         write enable, 3-bit register index, 8-bit data
//
//  One word is accepted per clock unless a stall at the output has filled every
//  stage; each word passes through the contrast, brightness and gain steps
//  (multiply, reciprocal multiply, quotient correction).
//  Every stage holds its own valid bit and loads whenever it is empty or the
//  stage after it moves, so a stall at the output fills the bubbles first.
//  Reset clears the valid bits and sets the registers to their defaults.
// ---------------------------------------------------------------------------
module rgb_contrast_brightness_gain_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // top_byte_in, red_in, green_in, blue_in
    // Output stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // top_byte_out, red_out, green_out, blue_out
    // Configuration writes
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data
);

    localparam int NSTG = rcbg_pkg::NSTG;

    logic             r_enable;
    logic [6:0]       r_bright;
    logic [7:0]       r_contrast;
    logic [7:0]       r_gain_r;
    logic [7:0]       r_gain_g;
    logic [7:0]       r_gain_b;

    logic [NSTG-1:0]  r_vld;
    logic [NSTG-1:0]  w_ld;
    logic [31:0]      r_raw [NSTG];
    logic [7:0]       w_red;
    logic [7:0]       w_grn;
    logic [7:0]       w_blu;
    logic             w_bypass;

    // Register writes, saturated into each register's range.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable   <= 1'b0;
            r_bright   <= 7'(rcbg_pkg::PCT_UNITY);
            r_contrast <= 8'(rcbg_pkg::PCT_UNITY);
            r_gain_r   <= 8'(rcbg_pkg::PCT_UNITY);
            r_gain_g   <= 8'(rcbg_pkg::PCT_UNITY);
            r_gain_b   <= 8'(rcbg_pkg::PCT_UNITY);
        end else if (i_cfg_we) begin
            unique case (rcbg_pkg::t_cfg_idx'(i_cfg_idx))
                rcbg_pkg::CFG_ENABLE: begin
                    r_enable <= i_cfg_data[0];
                end
                rcbg_pkg::CFG_BRIGHT: begin
                    r_bright <= 7'(rcbg_pkg::f_sat8({1'b0, i_cfg_data[6:0]},
                                                    8'(rcbg_pkg::BRIGHT_MIN),
                                                    8'(rcbg_pkg::BRIGHT_MAX)));
                end
                rcbg_pkg::CFG_CONTRAST: begin
                    r_contrast <= rcbg_pkg::f_sat8(i_cfg_data, 8'(rcbg_pkg::PCT_MIN),
                                                   8'(rcbg_pkg::PCT_MAX));
                end
                rcbg_pkg::CFG_RED_GAIN: begin
                    r_gain_r <= rcbg_pkg::f_sat8(i_cfg_data, 8'(rcbg_pkg::PCT_MIN),
                                                 8'(rcbg_pkg::PCT_MAX));
                end
                rcbg_pkg::CFG_GRN_GAIN: begin
                    r_gain_g <= rcbg_pkg::f_sat8(i_cfg_data, 8'(rcbg_pkg::PCT_MIN),
                                                 8'(rcbg_pkg::PCT_MAX));
                end
                rcbg_pkg::CFG_BLU_GAIN: begin
                    r_gain_b <= rcbg_pkg::f_sat8(i_cfg_data, 8'(rcbg_pkg::PCT_MIN),
                                                 8'(rcbg_pkg::PCT_MAX));
                end
                default: begin
                end
            endcase
        end
    end

    // A stage loads when it is empty or its contents move on.
    always_comb begin
        w_ld[NSTG-1] = !r_vld[NSTG-1] || i_m_axis_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_ld[k] = !r_vld[k] || w_ld[k+1];
        end
    end

    // Valid bits travel with the words.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_ld[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_ld[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Raw pixel delay line for the lowest byte and the bypass path.
    always_ff @(posedge i_clk) begin
        if (w_ld[0]) begin
            r_raw[0] <= i_s_axis_tdata;
        end
        for (int k = 1; k < NSTG; k++) begin
            if (w_ld[k]) begin
                r_raw[k] <= r_raw[k-1];
            end
        end
    end

    // One datapath per colour channel.
    rcbg_chan u_chan_r (
        .i_clk      (i_clk),
        .i_ld       (w_ld),
        .i_chan     (i_s_axis_tdata[15:8]),
        .i_contrast (r_contrast),
        .i_bright   (r_bright),
        .i_gain     (r_gain_r),
        .o_val      (w_red)
    );

    rcbg_chan u_chan_g (
        .i_clk      (i_clk),
        .i_ld       (w_ld),
        .i_chan     (i_s_axis_tdata[23:16]),
        .i_contrast (r_contrast),
        .i_bright   (r_bright),
        .i_gain     (r_gain_g),
        .o_val      (w_grn)
    );

    rcbg_chan u_chan_b (
        .i_clk      (i_clk),
        .i_ld       (w_ld),
        .i_chan     (i_s_axis_tdata[31:24]),
        .i_contrast (r_contrast),
        .i_bright   (r_bright),
        .i_gain     (r_gain_b),
        .o_val      (w_blu)
    );

    // Pixels pass unchanged when adjustment is off or every setting is unity.
    assign w_bypass = !r_enable ||
                      (r_bright   == 7'(rcbg_pkg::PCT_UNITY) &&
                       r_contrast == 8'(rcbg_pkg::PCT_UNITY) &&
                       r_gain_r   == 8'(rcbg_pkg::PCT_UNITY) &&
                       r_gain_g   == 8'(rcbg_pkg::PCT_UNITY) &&
                       r_gain_b   == 8'(rcbg_pkg::PCT_UNITY));

    // Output word.
    assign o_s_axis_tready = w_ld[0];
    assign o_m_axis_tvalid = r_vld[NSTG-1];
    assign o_m_axis_tdata  = w_bypass ? r_raw[NSTG-1]
                                      : {w_blu, w_grn, w_red, r_raw[NSTG-1][7:0]};

endmodule
